@@ design/fwsds_pkg.sv @@
// Shared types, codes and the command table of the steer/drive sequencer.
`timescale 1ns / 1ps
`default_nettype none

package fwsds_pkg;

    localparam int VALUE_W   = 16;
    localparam int TOL_W     = 15;
    localparam int OP_W      = 2;
    localparam int CMD_W     = 3;
    localparam int STAGE_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int S_TDATA_W = 136;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 136;
    localparam int M_TUSER_W = 3;

    typedef logic signed [VALUE_W-1:0] t_val;
    typedef t_val [3:0] t_quad;

    typedef struct packed {
        t_quad steer;
        t_quad drive;
    } t_signal;

    // item kinds
    localparam logic [OP_W-1:0] OP_COMMAND  = 2'd0;
    localparam logic [OP_W-1:0] OP_ABORT    = 2'd1;
    localparam logic [OP_W-1:0] OP_FEEDBACK = 2'd2;
    localparam logic [OP_W-1:0] OP_TICK     = 2'd3;

    // commands
    localparam logic [CMD_W-1:0] CMD_STOP       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FORWARD    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BACKWARD   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CRAB_LEFT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CRAB_RIGHT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_TURN_CCW   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_TURN_CW    = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED     = 3'd7;

    // sequencing stages
    localparam logic [STAGE_W-1:0] STAGE_IDLE  = 2'd0;
    localparam logic [STAGE_W-1:0] STAGE_STOP  = 2'd1;
    localparam logic [STAGE_W-1:0] STAGE_STEER = 2'd2;
    localparam logic [STAGE_W-1:0] STAGE_DRIVE = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_VELOCITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GEOMETRY_VALID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_ANGLE_LF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_ANGLE_RF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_ANGLE_LR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_ANGLE_RR  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_TOL      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_TOL      = 3'd7;

    localparam t_val HALF_PI_Q = 16'sd6434;

    function automatic t_signal command_table(
        input logic [CMD_W-1:0] cmd,
        input logic [TOL_W-1:0] velocity,
        input logic             geometry_valid,
        input t_quad            turn_angle
    );
        t_val    vp;
        t_val    vn;
        t_signal s;
        vp = t_val'({1'b0, velocity});
        vn = -vp;
        s  = '0;
        case (cmd)
            CMD_FORWARD: begin
                s.drive = {vp, vp, vp, vp};
            end
            CMD_BACKWARD: begin
                s.drive = {vn, vn, vn, vn};
            end
            CMD_CRAB_LEFT: begin
                s.steer = {-HALF_PI_Q, HALF_PI_Q, HALF_PI_Q, -HALF_PI_Q};
                s.drive = {vn, vp, vp, vn};
            end
            CMD_CRAB_RIGHT: begin
                s.steer = {-HALF_PI_Q, HALF_PI_Q, HALF_PI_Q, -HALF_PI_Q};
                s.drive = {vp, vn, vn, vp};
            end
            CMD_TURN_CCW: begin
                if (geometry_valid) begin
                    s.steer = turn_angle;
                    s.drive = {vp, vn, vp, vn};
                end
            end
            CMD_TURN_CW: begin
                if (geometry_valid) begin
                    s.steer = turn_angle;
                    s.drive = {vn, vp, vn, vp};
                end
            end
            default: begin
                s = '0;
            end
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ design/four_wheel_steer_drive_sequencer.sv @@
// Top level of the four-wheel steer/drive command sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Takes one item per cycle: a command, an abort, a feedback sample or a
// control tick, and returns one result transfer for each. Each item passes
// an input register, then a result register; the stop/steer/drive
// sequencing state updates as an item leaves the input register, so items
// follow each other back to back and only output backpressure stalls the
// input. Input tuser is the item kind; output tuser carries the
// signal_valid, sequencing and command_rejected flags. Configuration
// writes are taken at any cycle and must only happen while the block is
// empty.
module four_wheel_steer_drive_sequencer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [fwsds_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [fwsds_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    // cmd[2:0], safe_switch[3], meas_steer_lf/rf/lr/rr[67:4],
    // meas_drive_lf/rf/lr/rr[131:68], zero[135:132]
    input  wire logic [fwsds_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // op[1:0]
    input  wire logic [fwsds_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // out_steer_lf/rf/lr/rr[63:0], out_drive_lf/rf/lr/rr[127:64],
    // stage[129:128], zero[135:130]
    output      logic [fwsds_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // signal_valid[0], sequencing[1], command_rejected[2]
    output      logic [fwsds_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

    localparam int VW = fwsds_pkg::VALUE_W;
    localparam int TW = fwsds_pkg::TOL_W;

    // configuration
    logic [TW-1:0]                   r_velocity;
    logic                            r_geometry_valid;
    fwsds_pkg::t_quad                r_turn_angle;
    logic [TW-1:0]                   r_steer_tol;
    logic [TW-1:0]                   r_drive_tol;

    // sequencing state
    logic [fwsds_pkg::CMD_W-1:0]     r_cur_cmd,      n_cur_cmd;
    logic [fwsds_pkg::STAGE_W-1:0]   r_stage,        n_stage;
    logic                            r_step_reached, n_step_reached;
    logic                            r_forced,       n_forced;
    logic                            r_target_valid, n_target_valid;
    fwsds_pkg::t_quad                r_target,       n_target;
    fwsds_pkg::t_quad                r_last_steer,   n_last_steer;

    // input register
    logic                            r_in_valid;
    logic [fwsds_pkg::OP_W-1:0]      r_in_op;
    logic [fwsds_pkg::CMD_W-1:0]     r_in_cmd;
    logic                            r_in_safe;
    fwsds_pkg::t_quad                r_in_ms;
    fwsds_pkg::t_quad                r_in_md;

    // result register
    logic                            r_out_valid;
    logic [fwsds_pkg::M_TUSER_W-1:0] r_out_user,  n_out_user;
    fwsds_pkg::t_signal              r_out_sig,   n_out_sig;
    logic [fwsds_pkg::STAGE_W-1:0]   r_out_stage;

    logic                            out_free;
    logic                            advance;
    logic                            in_take;
    fwsds_pkg::t_quad                s_ms;
    fwsds_pkg::t_quad                s_md;
    fwsds_pkg::t_signal              cmd_sig;
    logic                            stopped;
    logic                            steered;
    logic signed [VW:0]              steer_err;
    logic signed [VW:0]              drive_ext;
    logic [VW:0]                     steer_abs;
    logic [VW:0]                     drive_abs;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            s_ms[i] = s_axis_tdata[4 + VW*i +: VW];
            s_md[i] = s_axis_tdata[4 + VW*(4+i) +: VW];
        end
    end

    assign cmd_sig = fwsds_pkg::command_table(r_cur_cmd, r_velocity, r_geometry_valid,
                                              r_turn_angle);

    always_comb begin
        stopped   = 1'b1;
        steered   = 1'b1;
        steer_err = '0;
        drive_ext = '0;
        steer_abs = '0;
        drive_abs = '0;
        for (int i = 0; i < 4; i++) begin
            drive_ext = {r_in_md[i][VW-1], r_in_md[i]};
            drive_abs = drive_ext[VW] ? (VW+1)'(-drive_ext) : drive_ext;
            if (drive_abs > {2'b00, r_drive_tol}) begin
                stopped = 1'b0;
            end
            steer_err = {r_in_ms[i][VW-1], r_in_ms[i]} - {r_target[i][VW-1], r_target[i]};
            steer_abs = steer_err[VW] ? (VW+1)'(-steer_err) : steer_err;
            if (steer_abs > {2'b00, r_steer_tol}) begin
                steered = 1'b0;
            end
        end
    end

    always_comb begin
        n_cur_cmd      = r_cur_cmd;
        n_stage        = r_stage;
        n_step_reached = r_step_reached;
        n_forced       = r_forced;
        n_target_valid = r_target_valid;
        n_target       = r_target;
        n_last_steer   = r_last_steer;
        n_out_user     = '0;
        n_out_sig      = '0;
        case (r_in_op)
            fwsds_pkg::OP_COMMAND: begin
                if ((r_in_cmd inside {fwsds_pkg::CMD_TURN_CCW, fwsds_pkg::CMD_TURN_CW}) &&
                    !r_geometry_valid) begin
                    n_out_user[2] = 1'b1;
                end else if (r_in_cmd != r_cur_cmd || r_in_cmd == fwsds_pkg::CMD_STOP) begin
                    n_cur_cmd = r_in_cmd;
                    if (r_in_safe) begin
                        n_stage        = fwsds_pkg::STAGE_STOP;
                        n_target_valid = 1'b0;
                        n_step_reached = 1'b0;
                        n_forced       = 1'b0;
                    end else begin
                        n_forced = 1'b1;
                    end
                end
            end
            fwsds_pkg::OP_ABORT: begin
                n_cur_cmd = fwsds_pkg::CMD_STOP;
                n_stage   = fwsds_pkg::STAGE_IDLE;
            end
            fwsds_pkg::OP_FEEDBACK: begin
                if (r_stage == fwsds_pkg::STAGE_STOP) begin
                    n_step_reached = stopped;
                end else if (r_stage == fwsds_pkg::STAGE_STEER) begin
                    n_step_reached = r_target_valid && steered && stopped;
                end
                n_last_steer = r_in_ms;
            end
            fwsds_pkg::OP_TICK: begin
                if (r_forced) begin
                    n_out_sig     = cmd_sig;
                    n_out_user[0] = 1'b1;
                end else if (r_stage != fwsds_pkg::STAGE_IDLE) begin
                    n_out_user[1:0] = 2'b11;
                    if (r_stage == fwsds_pkg::STAGE_STOP) begin
                        n_out_sig.steer = r_last_steer;
                        n_target_valid  = 1'b0;
                    end else if (r_stage == fwsds_pkg::STAGE_STEER) begin
                        n_out_sig.steer = cmd_sig.steer;
                        n_target        = cmd_sig.steer;
                        n_target_valid  = 1'b1;
                    end else begin
                        n_out_sig      = cmd_sig;
                        n_step_reached = 1'b1;
                        n_target_valid = 1'b0;
                    end
                    if (n_step_reached) begin
                        n_stage        = r_stage + 1'b1;
                        n_step_reached = 1'b0;
                    end
                end
            end
            default: begin
                n_out_user = '0;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_velocity       <= TW'(4096);
            r_geometry_valid <= 1'b0;
            r_turn_angle     <= '0;
            r_steer_tol      <= TW'(205);
            r_drive_tol      <= TW'(205);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fwsds_pkg::CFG_WHEEL_VELOCITY: r_velocity       <= i_cfg_wdata[TW-1:0];
                fwsds_pkg::CFG_GEOMETRY_VALID: r_geometry_valid <= i_cfg_wdata[0];
                fwsds_pkg::CFG_TURN_ANGLE_LF:  r_turn_angle[0]  <= i_cfg_wdata[VW-1:0];
                fwsds_pkg::CFG_TURN_ANGLE_RF:  r_turn_angle[1]  <= i_cfg_wdata[VW-1:0];
                fwsds_pkg::CFG_TURN_ANGLE_LR:  r_turn_angle[2]  <= i_cfg_wdata[VW-1:0];
                fwsds_pkg::CFG_TURN_ANGLE_RR:  r_turn_angle[3]  <= i_cfg_wdata[VW-1:0];
                fwsds_pkg::CFG_STEER_TOL:      r_steer_tol      <= i_cfg_wdata[TW-1:0];
                fwsds_pkg::CFG_DRIVE_TOL:      r_drive_tol      <= i_cfg_wdata[TW-1:0];
                default: begin
                    r_velocity <= r_velocity;
                end
            endcase
        end
    end

    // sequencing state and pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_cmd      <= fwsds_pkg::CMD_STOP;
            r_stage        <= fwsds_pkg::STAGE_IDLE;
            r_step_reached <= 1'b0;
            r_forced       <= 1'b0;
            r_target_valid <= 1'b0;
            r_last_steer   <= '0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (advance) begin
                r_cur_cmd      <= n_cur_cmd;
                r_stage        <= n_stage;
                r_step_reached <= n_step_reached;
                r_forced       <= n_forced;
                r_target_valid <= n_target_valid;
                r_last_steer   <= n_last_steer;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op   <= s_axis_tuser;
            r_in_cmd  <= s_axis_tdata[2:0];
            r_in_safe <= s_axis_tdata[3];
            r_in_ms   <= s_ms;
            r_in_md   <= s_md;
        end
        if (advance) begin
            r_target    <= n_target;
            r_out_user  <= n_out_user;
            r_out_sig   <= n_out_sig;
            r_out_stage <= n_stage;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tdata  = {6'b0, r_out_stage, r_out_sig.drive, r_out_sig.steer};

endmodule

`default_nettype wire

@@ design/fwsds_checker.sv @@
// Port-level checks of the steer/drive sequencer and their bind.
`timescale 1ns / 1ps
`default_nettype none

module fwsds_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [fwsds_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input wire logic [fwsds_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    // hold a stalled transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled output transfer changed");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_seq_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("sequencing without a drive signal");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[127:0] == '0)
        else $error("steer or drive nonzero without a drive signal");

    a_reject_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> !m_axis_tuser[0])
        else $error("rejected command together with a drive signal");

endmodule

bind four_wheel_steer_drive_sequencer fwsds_checker u_fwsds_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ bench/four_wheel_steer_drive_sequencer_test.sv @@
// Self-checking bench for the steer/drive sequencer: stimulus, scoreboard and timing.
`timescale 1ns / 1ps

module four_wheel_steer_drive_sequencer_test;

    import fwsds_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int STALL_CYCLES = 300;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [CMD_W-1:0] cmd;
        logic             safe;
        t_quad            steer;
        t_quad            drive;
    } t_rover_item;

    typedef struct packed {
        logic                sig_valid;
        logic                seq;
        logic                rejected;
        t_quad               steer;
        t_quad               drive;
        logic [STAGE_W-1:0]  stage;
    } t_rover_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    four_wheel_steer_drive_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // register copies
    logic [TOL_W-1:0] cfg_velocity = 15'd4096;
    logic             cfg_geom = 1'b0;
    t_quad            cfg_turn = '0;
    logic [TOL_W-1:0] cfg_steer_tol = 15'd205;
    logic [TOL_W-1:0] cfg_drive_tol = 15'd205;

    // sequencer state copy
    logic [CMD_W-1:0]   cur_cmd = CMD_STOP;
    logic [STAGE_W-1:0] wait_stage = STAGE_IDLE;
    logic               step_ok = 1'b0;
    logic               forced = 1'b0;
    logic               tgt_valid = 1'b0;
    t_quad              tgt_steer = '0;
    t_quad              last_steer = '0;

    t_rover_item   move_queue[$];
    t_rover_result predicted_outputs[$];
    t_rover_item   on_bus = '0;
    logic          in_fire = 1'b0;
    int            items_queued = 0;
    int            items_taken = 0;
    int            mismatch_count = 0;
    int            cycle_count = 0;
    int            stall_left = 0;
    logic          stall_done = 1'b0;
    logic          calm;
    string         wheel_tag[4] = '{"lf", "rf", "lr", "rr"};

    assign calm = (items_taken >= 350) && (items_taken < 470);

    function automatic void wheel_plan(input logic [CMD_W-1:0] c, output t_quad st,
                                       output t_quad dr);
        t_val vp;
        t_val vn;
        vp = t_val'({1'b0, cfg_velocity});
        vn = -vp;
        st = '0;
        dr = '0;
        case (c)
            CMD_FORWARD: begin
                for (int i = 0; i < 4; i++) dr[i] = vp;
            end
            CMD_BACKWARD: begin
                for (int i = 0; i < 4; i++) dr[i] = vn;
            end
            CMD_CRAB_LEFT, CMD_CRAB_RIGHT: begin
                st[0] = -HALF_PI_Q;
                st[1] = HALF_PI_Q;
                st[2] = HALF_PI_Q;
                st[3] = -HALF_PI_Q;
                dr[0] = vn;
                dr[1] = vp;
                dr[2] = vp;
                dr[3] = vn;
                if (c == CMD_CRAB_RIGHT) begin
                    for (int i = 0; i < 4; i++) dr[i] = -dr[i];
                end
            end
            CMD_TURN_CCW, CMD_TURN_CW: begin
                if (cfg_geom) begin
                    st = cfg_turn;
                    dr[0] = vn;
                    dr[1] = vp;
                    dr[2] = vn;
                    dr[3] = vp;
                    if (c == CMD_TURN_CW) begin
                        for (int i = 0; i < 4; i++) dr[i] = -dr[i];
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic t_rover_result step_rover(input t_rover_item it);
        t_rover_result r;
        t_quad         plan_s;
        t_quad         plan_d;
        logic          stopped;
        logic          steered;
        int            mag;
        r = '0;
        case (it.op)
            OP_COMMAND: begin
                if ((it.cmd == CMD_TURN_CCW || it.cmd == CMD_TURN_CW) && !cfg_geom) begin
                    r.rejected = 1'b1;
                end else if (it.cmd != cur_cmd || it.cmd == CMD_STOP) begin
                    cur_cmd = it.cmd;
                    if (it.safe) begin
                        wait_stage = STAGE_STOP;
                        tgt_valid  = 1'b0;
                        step_ok    = 1'b0;
                        forced     = 1'b0;
                    end else begin
                        forced = 1'b1;
                    end
                end
            end
            OP_ABORT: begin
                cur_cmd    = CMD_STOP;
                wait_stage = STAGE_IDLE;
            end
            OP_FEEDBACK: begin
                stopped = 1'b1;
                steered = 1'b1;
                for (int i = 0; i < 4; i++) begin
                    mag = int'($signed(it.drive[i]));
                    if (mag < 0) mag = -mag;
                    if (mag > int'(cfg_drive_tol)) stopped = 1'b0;
                    mag = int'($signed(it.steer[i])) - int'($signed(tgt_steer[i]));
                    if (mag < 0) mag = -mag;
                    if (mag > int'(cfg_steer_tol)) steered = 1'b0;
                end
                if (wait_stage == STAGE_STOP) begin
                    step_ok = stopped;
                end else if (wait_stage == STAGE_STEER) begin
                    step_ok = tgt_valid && steered && stopped;
                end
                last_steer = it.steer;
            end
            OP_TICK: begin
                if (forced) begin
                    wheel_plan(cur_cmd, r.steer, r.drive);
                    r.sig_valid = 1'b1;
                end else if (wait_stage != STAGE_IDLE) begin
                    wheel_plan(cur_cmd, plan_s, plan_d);
                    r.sig_valid = 1'b1;
                    r.seq       = 1'b1;
                    case (wait_stage)
                        STAGE_STOP: begin
                            r.steer   = last_steer;
                            tgt_valid = 1'b0;
                        end
                        STAGE_STEER: begin
                            r.steer   = plan_s;
                            tgt_steer = plan_s;
                            tgt_valid = 1'b1;
                        end
                        default: begin
                            r.steer   = plan_s;
                            r.drive   = plan_d;
                            step_ok   = 1'b1;
                            tgt_valid = 1'b0;
                        end
                    endcase
                    if (step_ok) begin
                        wait_stage = wait_stage + 1'b1;
                        step_ok    = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
        r.stage = wait_stage;
        return r;
    endfunction

    function automatic void compare_field(input string what, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    function automatic void check_output();
        t_rover_result want;
        t_rover_result got;
        got.sig_valid = m_axis_tuser[0];
        got.seq       = m_axis_tuser[1];
        got.rejected  = m_axis_tuser[2];
        got.steer     = m_axis_tdata[63:0];
        got.drive     = m_axis_tdata[127:64];
        got.stage     = m_axis_tdata[129:128];
        if (predicted_outputs.size() == 0) begin
            mismatch_count++;
            $display("%0t: stray result, expected none, actual %h", $time, got);
            return;
        end
        want = predicted_outputs.pop_front();
        compare_field("signal_valid", int'(want.sig_valid), int'(got.sig_valid));
        compare_field("sequencing", int'(want.seq), int'(got.seq));
        compare_field("command_rejected", int'(want.rejected), int'(got.rejected));
        for (int i = 0; i < 4; i++) begin
            compare_field({"out_steer_", wheel_tag[i]}, int'($signed(want.steer[i])),
                          int'($signed(got.steer[i])));
            compare_field({"out_drive_", wheel_tag[i]}, int'($signed(want.drive[i])),
                          int'($signed(got.drive[i])));
        end
        compare_field("stage", int'(want.stage), int'(got.stage));
    endfunction

    // check results first, then predict for the input transfer of this edge
    always @(posedge i_clk) begin
        in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_output();
        if (in_fire) begin
            predicted_outputs.push_back(step_rover(on_bus));
            items_taken++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (move_queue.size() != 0 && (calm || $urandom_range(99) >= 28)) begin
                on_bus = move_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {4'b0, on_bus.drive, on_bus.steer, on_bus.safe, on_bus.cmd};
                s_axis_tuser  <= on_bus.op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // hold off once for a long stretch so the block backs up into its input
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!stall_done && items_taken >= 100) begin
            stall_done = 1'b1;
            stall_left = STALL_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= 28);
        end
    end

    function automatic t_quad mk_quad(input int lf, input int rf, input int lr, input int rr);
        t_quad q;
        q[0] = t_val'(lf);
        q[1] = t_val'(rf);
        q[2] = t_val'(lr);
        q[3] = t_val'(rr);
        return q;
    endfunction

    function automatic t_val wild_val();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            default: return t_val'($urandom);
        endcase
    endfunction

    function automatic t_quad wild_quad();
        t_quad q;
        for (int i = 0; i < 4; i++) q[i] = wild_val();
        return q;
    endfunction

    function automatic t_val offset_val(input t_val c, input int off);
        int r;
        r = int'(c) + off;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return t_val'(r);
    endfunction

    // within tol of c, often right on the boundary
    function automatic t_quad near_quad(input t_quad c, input int tol);
        t_quad q;
        int    off;
        for (int i = 0; i < 4; i++) begin
            if ($urandom_range(3) == 0) off = $urandom_range(1) ? tol : -tol;
            else off = int'($urandom_range(2 * tol)) - tol;
            q[i] = offset_val(c[i], off);
        end
        return q;
    endfunction

    // at least one wheel just outside tol of c
    function automatic t_quad far_quad(input t_quad c, input int tol);
        t_quad q;
        int    off;
        int    k;
        q = near_quad(c, tol);
        k = $urandom_range(3);
        off = tol + 1 + int'($urandom_range(200));
        q[k] = offset_val(c[k], $urandom_range(1) ? off : -off);
        return q;
    endfunction

    function automatic void add_item(input logic [OP_W-1:0] op, input logic [CMD_W-1:0] c,
                                     input logic safe, input t_quad st, input t_quad dr);
        t_rover_item it;
        it.op    = op;
        it.cmd   = c;
        it.safe  = safe;
        it.steer = st;
        it.drive = dr;
        move_queue.push_back(it);
        items_queued++;
    endfunction

    function automatic void add_random(input logic [OP_W-1:0] op);
        add_item(op, CMD_W'($urandom_range(7)), 1'($urandom_range(1)), wild_quad(),
                 wild_quad());
    endfunction

    // safe command walked through stop, steer and drive with plausible feedback
    function automatic void add_sequence();
        logic [CMD_W-1:0] c;
        t_quad            ps;
        t_quad            pd;
        t_quad            zq;
        int               stol;
        int               dtol;
        zq   = '0;
        stol = int'(cfg_steer_tol);
        dtol = int'(cfg_drive_tol);
        c    = CMD_W'($urandom_range(7));
        add_item(OP_COMMAND, c, 1'b1, wild_quad(), wild_quad());
        wheel_plan(c, ps, pd);
        if ($urandom_range(3) == 0) add_random(OP_TICK);
        if ($urandom_range(4) == 0) begin
            add_item(OP_FEEDBACK, CMD_W'($urandom_range(7)), 1'($urandom_range(1)),
                     wild_quad(), far_quad(zq, dtol));
            add_random(OP_TICK);
        end
        add_item(OP_FEEDBACK, CMD_W'($urandom_range(7)), 1'($urandom_range(1)), wild_quad(),
                 near_quad(zq, dtol));
        add_random(OP_TICK);
        add_random(OP_TICK);
        if ($urandom_range(4) == 0) begin
            add_item(OP_FEEDBACK, CMD_W'($urandom_range(7)), 1'($urandom_range(1)),
                     far_quad(ps, stol), near_quad(zq, dtol));
            add_random(OP_TICK);
        end
        if ($urandom_range(9) == 0) add_random(OP_ABORT);
        add_item(OP_FEEDBACK, CMD_W'($urandom_range(7)), 1'($urandom_range(1)),
                 near_quad(ps, stol), near_quad(zq, dtol));
        add_random(OP_TICK);
        add_random(OP_TICK);
        if ($urandom_range(2) == 0) add_random(OP_TICK);
    endfunction

    function automatic void fill_phase(input int count);
        int start;
        start = items_queued;
        while (items_queued - start < count) begin
            if ($urandom_range(3) != 0) begin
                add_sequence();
            end else begin
                repeat ($urandom_range(1, 4)) add_random(OP_W'($urandom_range(3)));
            end
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_WHEEL_VELOCITY: cfg_velocity = val[TOL_W-1:0];
            CFG_GEOMETRY_VALID: cfg_geom = val[0];
            CFG_TURN_ANGLE_LF:  cfg_turn[0] = val;
            CFG_TURN_ANGLE_RF:  cfg_turn[1] = val;
            CFG_TURN_ANGLE_LR:  cfg_turn[2] = val;
            CFG_TURN_ANGLE_RR:  cfg_turn[3] = val;
            CFG_STEER_TOL:      cfg_steer_tol = val[TOL_W-1:0];
            CFG_DRIVE_TOL:      cfg_drive_tol = val[TOL_W-1:0];
            default: begin
            end
        endcase
    endtask

    task automatic load_config(input logic [TOL_W-1:0] vel, input logic geom, input t_quad ang,
                               input logic [TOL_W-1:0] stol, input logic [TOL_W-1:0] dtol);
        write_reg(CFG_WHEEL_VELOCITY, {1'b0, vel});
        write_reg(CFG_GEOMETRY_VALID, {15'b0, geom});
        write_reg(CFG_TURN_ANGLE_LF, ang[0]);
        write_reg(CFG_TURN_ANGLE_RF, ang[1]);
        write_reg(CFG_TURN_ANGLE_LR, ang[2]);
        write_reg(CFG_TURN_ANGLE_RR, ang[3]);
        write_reg(CFG_STEER_TOL, {1'b0, stol});
        write_reg(CFG_DRIVE_TOL, {1'b0, dtol});
    endtask

    task automatic drain();
        while (items_taken != items_queued || predicted_outputs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        t_quad zq;
        zq = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: no geometry, default tolerances
        add_item(OP_TICK, CMD_STOP, 1'b0, zq, zq);
        add_item(OP_FEEDBACK, CMD_STOP, 1'b0, mk_quad(-32768, 32767, -32768, 32767),
                 mk_quad(32767, -32768, 0, 205));
        add_item(OP_COMMAND, CMD_TURN_CCW, 1'b1, zq, zq);
        add_item(OP_COMMAND, CMD_TURN_CW, 1'b0, zq, zq);
        add_item(OP_COMMAND, CMD_FORWARD, 1'b1, zq, zq);
        add_item(OP_TICK, CMD_STOP, 1'b0, zq, zq);
        add_item(OP_FEEDBACK, CMD_STOP, 1'b0, zq, mk_quad(205, -205, 0, 206));
        add_item(OP_TICK, CMD_STOP, 1'b0, zq, zq);
        add_item(OP_FEEDBACK, CMD_STOP, 1'b0, zq, mk_quad(205, -205, 0, -205));
        add_item(OP_TICK, CMD_STOP, 1'b0, zq, zq);
        add_item(OP_TICK, CMD_STOP, 1'b0, zq, zq);
        add_item(OP_FEEDBACK, CMD_STOP, 1'b0, mk_quad(205, -205, 0, 0), zq);
        add_item(OP_TICK, CMD_STOP, 1'b0, zq, zq);
        add_item(OP_TICK, CMD_STOP, 1'b0, zq, zq);
        add_item(OP_COMMAND, CMD_FORWARD, 1'b1, zq, zq);
        add_item(OP_COMMAND, CMD_CRAB_LEFT, 1'b0, zq, zq);
        add_item(OP_TICK, CMD_STOP, 1'b0, zq, zq);
        add_item(OP_ABORT, CMD_STOP, 1'b0, zq, zq);
        add_item(OP_TICK, CMD_STOP, 1'b0, zq, zq);
        add_item(OP_COMMAND, CMD_UNUSED, 1'b0, zq, zq);
        add_item(OP_TICK, CMD_STOP, 1'b0, zq, zq);
        add_item(OP_COMMAND, CMD_STOP, 1'b1, zq, zq);
        add_item(OP_COMMAND, CMD_CRAB_RIGHT, 1'b1, zq, zq);
        add_item(OP_ABORT, CMD_STOP, 1'b0, zq, zq);
        add_item(OP_FEEDBACK, CMD_BACKWARD, 1'b1, mk_quad(32767, -32768, 32767, -32768),
                 mk_quad(-32768, -32768, -32768, -32768));
        drain();

        // top speed, zero tolerances, geometry known
        load_config(15'h7fff, 1'b1, mk_quad(-32768, 32767, 1234, -4321), 15'd0, 15'd0);
        add_item(OP_COMMAND, CMD_TURN_CCW, 1'b0, zq, zq);
        add_random(OP_TICK);
        fill_phase(150);
        // leave a forced turn in place for the geometry to be withdrawn under it
        add_item(OP_ABORT, CMD_STOP, 1'b0, zq, zq);
        add_item(OP_COMMAND, CMD_TURN_CW, 1'b0, zq, zq);
        drain();

        // zero speed, widest tolerances, geometry withdrawn
        load_config(15'd0, 1'b0, wild_quad(), 15'h7fff, 15'h7fff);
        add_random(OP_TICK);
        add_item(OP_COMMAND, CMD_TURN_CW, 1'b1, zq, zq);
        fill_phase(150);
        drain();

        repeat (3) begin
            load_config(TOL_W'(($urandom_range(3) == 0) ? $urandom_range(32767)
                                                         : $urandom_range(8192)),
                        1'($urandom_range(1)), wild_quad(),
                        TOL_W'(($urandom_range(4) == 0) ? $urandom_range(32767)
                                                         : $urandom_range(1000)),
                        TOL_W'(($urandom_range(4) == 0) ? $urandom_range(32767)
                                                         : $urandom_range(1000)));
            fill_phase(150);
            drain();
        end

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
